// ----- src/whp_pkg.sv -----
// whp_pkg: shared types and constants for the wav header parser
// result record, result kinds, error codes and riff tag values
// no dependencies
package whp_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [31:0] DefaultRateReset = 32'd44100;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] KIND_FORMAT  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NOT_RIFF  = 3'd0;
  localparam logic [2:0] ERR_NON_PCM   = 3'd1;
  localparam logic [2:0] ERR_CHANNELS  = 3'd2;
  localparam logic [2:0] ERR_BITS      = 3'd3;
  localparam logic [2:0] ERR_EARLY_END = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic        stereo;
    logic        eight_bit;
    logic [31:0] sample_rate;
    logic [31:0] sample_count;
    logic [1:0]  skip_left;
    logic [1:0]  skip_right;
    logic [7:0]  payload_byte;
    logic        last;
    logic [2:0]  error_code;
  } result_t;

endpackage

// ----- src/wav_header_parser_top.sv -----
// wav_header_parser_top: riff/wav pcm header parser with streaming channels
// usage:
//   in_*  : one file byte per transfer, in_tdata = in_byte, in_tlast = end of file
//   out_* : result records; out_tuser = kind (0 format, 1 payload, 2 error),
//           out_tlast = last payload byte, or payload byte at end of file
//   cfg_* : write of the default sample rate, always ready, take it while idle
// a byte is parsed in the cycle it is taken; its result, if any, is written to
// a small queue and shows on out_* once it reaches the head of the queue
// throughput is one byte per cycle, sustained while the receiver keeps up;
// the queue depth (QUEUE_DEPTH, default 2) sets how many results can wait
// when out_tready is low in_tready drops once the queue is full, and no
// result is lost or repeated; the parser state holds while no byte arrives
// reset (rst_n low, synchronous) empties the queue, rearms the parser to
// expect a riff tag and loads the default rate with 44100
// after an error or after the payload, bytes are dropped up to end of file
// depends on whp_pkg, whp_front, whp_fifo
module wav_header_parser_top #(
  parameter int unsigned QUEUE_DEPTH = whp_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] stereo, [1] eight_bit, [33:2] sample_rate, [65:34] sample_count,
  // [67:66] skip_left, [69:68] skip_right, [77:70] payload_byte,
  // [80:78] error_code, [87:81] zero
  output logic [87:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import whp_pkg::*;

  logic    byte_accept;
  logic    res_valid;
  result_t res;
  logic    q_full;
  result_t head;

  assign in_tready   = !q_full;
  assign byte_accept = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;

  whp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .in_byte     (in_tdata),
    .end_of_file (in_tlast),
    .cfg_write   (cfg_valid),
    .cfg_rate    (cfg_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  whp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (byte_accept && res_valid),
    .push_data  (res),
    .full       (q_full),
    .head_valid (out_tvalid),
    .pop        (out_tready),
    .head       (head)
  );

  assign out_tdata = {7'd0, head.error_code, head.payload_byte, head.skip_right,
                      head.skip_left, head.sample_count, head.sample_rate,
                      head.eight_bit, head.stereo};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ----- src/whp_front.sv -----
// whp_front: byte-serial riff/wav parser, one byte per accepted transfer
// classifies each byte and issues at most one result record per byte
// depends on whp_pkg
module whp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_file,
  input  logic              cfg_write,
  input  logic [31:0]       cfg_rate,
  output logic              res_valid,
  output whp_pkg::result_t  res
);
  import whp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF, PH_SKIP8, PH_FIRST_HDR, PH_FMT, PH_HDR,
    PH_SKIP, PH_PAYLOAD, PH_DONE, PH_FAILED
  } phase_t;

  typedef struct packed {
    logic       stereo;
    logic       eight_bit;
    logic [1:0] skip_left;
    logic [1:0] skip_right;
    logic       fmt_seen;
  } flags_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [15:0] fmt_tag_r, fmt_tag_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  flags_t      flags_r, flags_nxt;
  logic [31:0] default_rate_r;
  logic [31:0] size;
  logic [31:0] cnt;
  logic [15:0] bits;
  flags_t      judged;
  logic        bad_chans;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    tag_nxt    = tag_r;
    remain_nxt = remain_r;
    fmt_tag_nxt = fmt_tag_r;
    chans_nxt  = chans_r;
    rate_nxt   = rate_r;
    flags_nxt  = flags_r;
    res_valid  = 1'b0;
    res        = '0;
    word_nxt   = {in_byte, word_r[31:8]};
    size       = word_nxt;
    bits       = word_nxt[31:16];
    cnt        = size >> ({1'b0, flags_r.stereo} + {1'b0, ~flags_r.eight_bit});

    judged          = '0;
    judged.fmt_seen = 1'b1;
    bad_chans       = 1'b0;
    case (chans_r)
      16'd1: ;
      16'd2: judged.stereo = 1'b1;
      16'd3: begin
        judged.stereo = 1'b1;
        judged.skip_right = 2'd1;
      end
      16'd4: begin
        judged.stereo = 1'b1;
        judged.skip_right = 2'd2;
      end
      16'd6: begin
        judged.stereo = 1'b1;
        judged.skip_left = 2'd3;
        judged.skip_right = 2'd1;
      end
      default: bad_chans = 1'b1;
    endcase
    judged.eight_bit = (bits <= 16'd8);

    case (phase_r)
      PH_RIFF: begin
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd3) begin
          idx_nxt = '0;
          if (word_nxt != TAG_RIFF) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_NOT_RIFF;
            phase_nxt = PH_FAILED;
          end else begin
            phase_nxt = PH_SKIP8;
          end
        end
      end
      PH_SKIP8: begin
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd7) begin
          idx_nxt = '0;
          phase_nxt = PH_FIRST_HDR;
        end
      end
      PH_FIRST_HDR, PH_HDR: begin
        if (idx_r == 4'd3) tag_nxt = word_nxt;
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd7) begin
          idx_nxt = '0;
          if (phase_r == PH_FIRST_HDR && tag_r == TAG_FMT && size == 32'd16) begin
            phase_nxt = PH_FMT;
          end else if (tag_r == TAG_DATA) begin
            res_valid = 1'b1;
            res.kind = KIND_FORMAT;
            res.stereo = flags_r.stereo;
            res.eight_bit = flags_r.eight_bit;
            res.sample_rate = flags_r.fmt_seen ? rate_r : default_rate_r;
            res.sample_count = cnt;
            res.skip_left = flags_r.skip_left;
            res.skip_right = flags_r.skip_right;
            remain_nxt = size;
            phase_nxt = (size == '0) ? PH_DONE : PH_PAYLOAD;
          end else begin
            remain_nxt = size;
            phase_nxt = (size == '0) ? PH_HDR : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (idx_r == 4'd1) fmt_tag_nxt = word_nxt[31:16];
        if (idx_r == 4'd3) chans_nxt = word_nxt[31:16];
        if (idx_r == 4'd7) rate_nxt = word_nxt;
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd15) begin
          idx_nxt = '0;
          phase_nxt = PH_HDR;
          if (fmt_tag_r != 16'd1) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_NON_PCM;
            phase_nxt = PH_FAILED;
          end else if (bad_chans) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_CHANNELS;
            phase_nxt = PH_FAILED;
          end else if (bits > 16'd16) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_BITS;
            phase_nxt = PH_FAILED;
          end else begin
            flags_nxt = judged;
          end
        end
      end
      PH_SKIP: begin
        remain_nxt = remain_r - 32'd1;
        if (remain_nxt == '0) phase_nxt = PH_HDR;
      end
      PH_PAYLOAD: begin
        remain_nxt = remain_r - 32'd1;
        res_valid = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.payload_byte = in_byte;
        res.last = (remain_nxt == '0) || end_of_file;
        if (remain_nxt == '0) phase_nxt = PH_DONE;
      end
      default: ;
    endcase

    if (end_of_file) begin
      if (!res_valid && (phase_nxt == PH_RIFF || phase_nxt == PH_SKIP8 ||
          phase_nxt == PH_FIRST_HDR || phase_nxt == PH_FMT ||
          phase_nxt == PH_HDR || phase_nxt == PH_SKIP)) begin
        res_valid = 1'b1;
        res.kind = KIND_ERROR;
        res.error_code = ERR_EARLY_END;
      end
      phase_nxt   = PH_RIFF;
      idx_nxt     = '0;
      word_nxt    = '0;
      tag_nxt     = '0;
      remain_nxt  = '0;
      fmt_tag_nxt = '0;
      chans_nxt   = '0;
      rate_nxt    = '0;
      flags_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RIFF;
      idx_r    <= '0;
      word_r   <= '0;
      tag_r    <= '0;
      remain_r <= '0;
      fmt_tag_r <= '0;
      chans_r  <= '0;
      rate_r   <= '0;
      flags_r  <= '0;
      default_rate_r <= DefaultRateReset;
    end else begin
      if (cfg_write) default_rate_r <= cfg_rate;
      if (byte_accept) begin
        phase_r  <= phase_nxt;
        idx_r    <= idx_nxt;
        word_r   <= word_nxt;
        tag_r    <= tag_nxt;
        remain_r <= remain_nxt;
        fmt_tag_r <= fmt_tag_nxt;
        chans_r  <= chans_nxt;
        rate_r   <= rate_nxt;
        flags_r  <= flags_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_payload_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (remain_r != '0))
    else $error("payload phase with no bytes left");
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FMT) |-> (idx_r <= 4'd7))
    else $error("byte index out of range outside fmt body");
  a_eof_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_accept && end_of_file) |=> (phase_r == PH_RIFF && idx_r == '0))
    else $error("parser did not rearm after end of file");
`endif

endmodule

// ----- src/whp_fifo.sv -----
// whp_fifo: short result queue between parser and output channel
// head entry drives the output channel directly
// depends on whp_pkg
module whp_fifo #(
  parameter int unsigned DEPTH = whp_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  whp_pkg::result_t  push_data,
  output logic              full,
  output logic              head_valid,
  input  logic              pop,
  output whp_pkg::result_t  head
);
  import whp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full       = (count_r == FullCount);
  assign head_valid = (count_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PW'(1);
      if (push && !do_pop) count_r <= count_r + CW'(1);
      else if (!push && do_pop) count_r <= count_r - CW'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCount)
    else $error("queue count beyond depth");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> head_valid)
    else $error("pushed entry not visible");
`endif

endmodule

// ----- tb/wav_header_parser_top_tb.sv -----
// wav_header_parser_top_tb: self-checking bench for the wav header parser top level
// feeds riff files one byte per transfer, predicts every result and checks each one
// depends on whp_pkg and wav_header_parser_top
module wav_header_parser_top_tb;
  import whp_pkg::*;

  localparam int CycleLimit = 300000;

  class wav_expect_board;
    typedef enum logic [3:0] {
      P_RIFF, P_SKIP8, P_FIRST_HDR, P_FMT, P_HDR, P_SKIP, P_PAYLOAD, P_DONE, P_FAILED
    } parse_phase_e;

    logic [31:0]  default_rate;
    parse_phase_e phase;
    logic [31:0]  idx, word, tag, remaining, rate;
    logic [15:0]  fmt_tag, chans, bits;
    bit           fmt_seen, stereo, eight;
    logic [1:0]   skip_l, skip_r;
    result_t      expected[$];
    int           errors, checked;

    function new();
      default_rate = DefaultRateReset;
      errors = 0;
      checked = 0;
      rearm();
    endfunction

    function void rearm();
      phase = P_RIFF;
      idx = '0;
      word = '0;
      tag = '0;
      remaining = '0;
      rate = '0;
      fmt_tag = '0;
      chans = '0;
      bits = '0;
      fmt_seen = 0;
      stereo = 0;
      eight = 0;
      skip_l = '0;
      skip_r = '0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // returns 1 when the byte was parsed rather than dropped
    function bit note_input(logic [7:0] b, logic eof);
      result_t      r;
      bit           got, ok;
      parse_phase_e p0;
      logic [31:0]  cnt;
      logic [2:0]   code;
      logic         n_stereo;
      logic [1:0]   n_sl, n_sr;
      r = '0;
      got = 0;
      p0 = phase;
      word = {b, word[31:8]};
      case (phase)
        P_RIFF: begin
          idx++;
          if (idx >= 4) begin
            idx = '0;
            if (word != TAG_RIFF) begin
              r.kind = KIND_ERROR;
              r.error_code = ERR_NOT_RIFF;
              phase = P_FAILED;
              got = 1;
            end else begin
              phase = P_SKIP8;
            end
          end
        end
        P_SKIP8: begin
          idx++;
          if (idx >= 8) begin
            idx = '0;
            phase = P_FIRST_HDR;
          end
        end
        P_FIRST_HDR, P_HDR: begin
          if (idx == 3) tag = word;
          idx++;
          if (idx >= 8) begin
            idx = '0;
            if (p0 == P_FIRST_HDR && tag == TAG_FMT && word == 32'd16) begin
              phase = P_FMT;
            end else if (tag == TAG_DATA) begin
              cnt = word;
              if (stereo) cnt = cnt >> 1;
              if (!eight) cnt = cnt >> 1;
              r.kind = KIND_FORMAT;
              r.stereo = stereo;
              r.eight_bit = eight;
              r.sample_rate = fmt_seen ? rate : default_rate;
              r.sample_count = cnt;
              r.skip_left = skip_l;
              r.skip_right = skip_r;
              got = 1;
              remaining = word;
              phase = (word == 0) ? P_DONE : P_PAYLOAD;
            end else begin
              remaining = word;
              phase = (word == 0) ? P_HDR : P_SKIP;
            end
          end
        end
        P_FMT: begin
          if (idx == 1) fmt_tag = word[31:16];
          else if (idx == 3) chans = word[31:16];
          else if (idx == 7) rate = word;
          else if (idx == 15) bits = word[31:16];
          idx++;
          if (idx >= 16) begin
            idx = '0;
            ok = 1;
            code = ERR_NON_PCM;
            n_stereo = 1;
            n_sl = '0;
            n_sr = '0;
            if (fmt_tag != 16'd1) begin
              ok = 0;
            end else begin
              case (chans)
                16'd1: n_stereo = 0;
                16'd2: ;
                16'd3: n_sr = 2'd1;
                16'd4: n_sr = 2'd2;
                16'd6: begin
                  n_sl = 2'd3;
                  n_sr = 2'd1;
                end
                default: begin
                  ok = 0;
                  code = ERR_CHANNELS;
                end
              endcase
              if (ok && bits > 16'd16) begin
                ok = 0;
                code = ERR_BITS;
              end
            end
            if (ok) begin
              fmt_seen = 1;
              stereo = n_stereo;
              eight = (bits <= 16'd8);
              skip_l = n_sl;
              skip_r = n_sr;
              phase = P_HDR;
            end else begin
              r.kind = KIND_ERROR;
              r.error_code = code;
              phase = P_FAILED;
              got = 1;
            end
          end
        end
        P_SKIP: begin
          remaining--;
          if (remaining == 0) phase = P_HDR;
        end
        P_PAYLOAD: begin
          remaining--;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.last = (remaining == 0) || eof;
          got = 1;
          if (remaining == 0) phase = P_DONE;
        end
        default: ;
      endcase
      if (eof) begin
        if (!got && phase <= P_SKIP) begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_EARLY_END;
          got = 1;
        end
        rearm();
      end
      if (got) expected.push_back(r);
      return !(p0 == P_DONE || p0 == P_FAILED);
    endfunction

    task report(string what, logic [31:0] e, logic [31:0] g);
      errors++;
      $display("mismatch in %s: expected 0x%0h, got 0x%0h (result %0d)", what, e, g, checked);
    endtask

    task check_result(result_t g);
      result_t e;
      if (expected.size() == 0) begin
        report("unexpected result, kind", '0, g.kind);
        return;
      end
      e = expected.pop_front();
      checked++;
      if (g.kind !== e.kind) report("kind", e.kind, g.kind);
      if (g.stereo !== e.stereo) report("stereo", e.stereo, g.stereo);
      if (g.eight_bit !== e.eight_bit) report("eight_bit", e.eight_bit, g.eight_bit);
      if (g.sample_rate !== e.sample_rate) report("sample_rate", e.sample_rate, g.sample_rate);
      if (g.sample_count !== e.sample_count)
        report("sample_count", e.sample_count, g.sample_count);
      if (g.skip_left !== e.skip_left) report("skip_left", e.skip_left, g.skip_left);
      if (g.skip_right !== e.skip_right) report("skip_right", e.skip_right, g.skip_right);
      if (g.payload_byte !== e.payload_byte)
        report("payload_byte", e.payload_byte, g.payload_byte);
      if (g.last !== e.last) report("last", e.last, g.last);
      if (g.error_code !== e.error_code) report("error_code", e.error_code, g.error_code);
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid, cfg_ready;
  logic [31:0] cfg_data;

  wav_expect_board sb;
  logic [7:0]  file_q[$];
  logic [31:0] valid_chans[5] = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd6};
  bit          quiet, calm_tx, calm_rx;
  int          files, live_bytes, rate_writes, cycle_count;

  wav_header_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    calm_rx = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) calm_rx = !calm_rx;
      if (!quiet && !calm_rx && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t g;
    if (rst_n && out_tvalid && out_tready) begin
      g.kind = out_tuser;
      g.stereo = out_tdata[0];
      g.eight_bit = out_tdata[1];
      g.sample_rate = out_tdata[33:2];
      g.sample_count = out_tdata[65:34];
      g.skip_left = out_tdata[67:66];
      g.skip_right = out_tdata[69:68];
      g.payload_byte = out_tdata[77:70];
      g.error_code = out_tdata[80:78];
      g.last = out_tlast;
      sb.check_result(g);
    end
  end

  function void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  // lead, fsize and mid below zero leave that chunk out
  function void build_wav(int lead, int fsize, logic [31:0] ftag, logic [31:0] chans,
                          logic [31:0] rate, logic [31:0] bits, int mid, bit mid_fmt,
                          logic [31:0] dsize, int body);
    file_q.delete();
    put_le(TAG_RIFF, 4);
    put_le($urandom, 4);
    put_le($urandom, 4);
    if (lead >= 0) begin
      put_le($urandom, 4);
      put_le(lead, 4);
      repeat (lead) put_le($urandom, 1);
    end
    if (fsize >= 0) begin
      put_le(TAG_FMT, 4);
      put_le(fsize, 4);
      put_le(ftag, 2);
      put_le(chans, 2);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(bits, 2);
      for (int i = 16; i < fsize; i++) put_le($urandom, 1);
    end
    if (mid >= 0) begin
      put_le(mid_fmt ? TAG_FMT : $urandom, 4);
      put_le(mid, 4);
      repeat (mid) put_le($urandom, 1);
    end
    put_le(TAG_DATA, 4);
    put_le(dsize, 4);
    repeat (body) put_le($urandom, 1);
  endfunction

  task send_byte(logic [7:0] b, logic eof);
    if ($urandom_range(0, 49) == 0) calm_tx = !calm_tx;
    if (!quiet && !calm_tx && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eof;
    do @(posedge clk); while (!in_tready);
    if (sb.note_input(b, eof)) live_bytes++;
  endtask

  // cut of zero sends the whole file, else only its first cut bytes
  task send_file(int cut);
    int n;
    n = file_q.size();
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
    files++;
  endtask

  task settle();
    int k;
    @(negedge clk);
    in_tvalid <= 1'b0;
    for (k = 0; k < 5000 && sb.pending() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_rate(logic [31:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.default_rate = v;
    rate_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          rand_start, last_cfg, pick, cut, lead, fsize, mid, body;
    logic [31:0] ftag, chans, bits, dsize;
    bit          mid_fmt;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 0;
    calm_tx = 0;
    files = 0;
    live_bytes = 0;
    rate_writes = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no fmt chunk, rate from reset value and then from a written value
    build_wav(-1, -1, 0, 0, 0, 0, -1, 0, 4, 4);
    send_file(0);
    write_rate(32'd0);
    build_wav(2, -1, 0, 0, 0, 0, -1, 0, 6, 6);
    send_file(0);
    write_rate(32'hFFFF_FFFF);
    // first chunk fmt of wrong size is skipped
    build_wav(-1, 18, 1, 2, 32'h1234, 8, -1, 0, 4, 4);
    send_file(0);
    // channel and bits decoding, later fmt skipped, empty data
    build_wav(-1, 16, 1, 1, 8000, 8, -1, 0, 3, 3);
    send_file(0);
    build_wav(-1, 16, 1, 2, 32'hFFFF_FFFF, 16, -1, 0, 8, 8);
    send_file(0);
    build_wav(-1, 16, 1, 3, 0, 9, 3, 1, 6, 6);
    send_file(0);
    build_wav(-1, 16, 1, 4, 22050, 0, -1, 0, 5, 5);
    send_file(0);
    build_wav(-1, 16, 1, 6, 48000, 1, -1, 0, 0, 3);
    send_file(0);
    // format errors in check order
    build_wav(-1, 16, 3, 5, 0, 17, -1, 0, 4, 4);
    send_file(0);
    build_wav(-1, 16, 1, 0, 0, 17, -1, 0, 4, 4);
    send_file(0);
    build_wav(-1, 16, 1, 5, 0, 8, -1, 0, 4, 4);
    send_file(0);
    build_wav(-1, 16, 1, 2, 0, 17, -1, 0, 4, 4);
    send_file(0);
    send_file(36);
    // bad riff tag ending on its own last byte, early ends
    file_q[0] = 8'h72;
    send_file(4);
    build_wav(-1, 16, 1, 1, 11025, 8, -1, 0, 4, 4);
    send_file(10);
    send_file(17);
    send_file(30);
    send_file(44);
    // truncated payloads of huge data chunks, payload overrun
    build_wav(-1, 16, 1, 1, 1, 8, -1, 0, 32'hFFFF_FFFF, 6);
    send_file(0);
    build_wav(-1, 16, 1, 2, 2, 16, -1, 0, 32'hFFFF_FFFF, 3);
    send_file(0);
    build_wav(-1, 16, 1, 1, 3, 7, -1, 0, 2, 5);
    send_file(0);

    rand_start = live_bytes;
    last_cfg = live_bytes;
    while (live_bytes - rand_start < 400) begin
      quiet = (live_bytes - rand_start >= 340);
      if (live_bytes - last_cfg > 90) begin
        case ($urandom_range(0, 3))
          0: write_rate(32'd0);
          1: write_rate(32'hFFFF_FFFF);
          2: write_rate(DefaultRateReset);
          default: write_rate($urandom);
        endcase
        last_cfg = live_bytes;
      end
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        file_q.delete();
        repeat ($urandom_range(1, 16)) put_le($urandom, 1);
        send_file(0);
      end else begin
        lead = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : -1;
        case ($urandom_range(0, 9))
          7: fsize = -1;
          8: fsize = 18;
          9: fsize = 20;
          default: fsize = 16;
        endcase
        ftag = ($urandom_range(0, 7) == 0) ? ($urandom & 32'hFFFF) : 32'd1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: chans = valid_chans[$urandom_range(0, 4)];
          9: chans = $urandom & 32'hFFFF;
          default: chans = $urandom_range(0, 7);
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2: bits = 32'd8;
          3, 4, 5: bits = 32'd16;
          9: bits = $urandom & 32'hFFFF;
          default: bits = $urandom_range(0, 24);
        endcase
        mid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : -1;
        mid_fmt = $urandom_range(0, 1);
        dsize = ($urandom_range(0, 11) == 0) ? $urandom : $urandom_range(0, 24);
        body = (dsize <= 24) ? dsize + $urandom_range(0, 3) : $urandom_range(1, 12);
        build_wav(lead, fsize, ftag, chans, $urandom, bits, mid, mid_fmt, dsize, body);
        cut = 0;
        if (pick >= 7) begin
          if ($urandom_range(0, 1) == 0)
            cut = $urandom_range(1, file_q.size());
          else
            file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'($urandom_range(1, 255));
        end
        send_file(cut);
      end
    end

    settle();
    repeat (6) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still expected at end", sb.pending(), 0);
    $display("covered %0d files, %0d parsed bytes, %0d results checked, %0d rate writes",
             files, live_bytes, sb.checked, rate_writes);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
